>>> src/fhed_pkg.sv
// ----------------------------------------------------------------------------
// fhed_pkg
// Shared types and constants for the filtered hysteresis edge detector.
// ----------------------------------------------------------------------------
package fhed_pkg;

    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int TIME_BITS        = 32;
    localparam int CONFIRM_BITS     = 16;
    localparam int PCT_BITS         = 6;
    localparam int APB_ADDR_BITS    = 5;
    localparam int APB_DATA_BITS    = 32;

    localparam int DEF_THR_LOW      = 1900;
    localparam int DEF_THR_HIGH     = 2200;
    localparam int DEF_CONFIRM      = 200;
    localparam int DEF_HYST_PCT     = 10;
    localparam int DEF_MIN_CONTRAST = 100;

    localparam int HYST_MIN         = 2;
    localparam int PCT_DIVISOR      = 100;
    // bits needed to cover PCT_DIVISOR
    localparam int PCT_DIV_BITS     = 7;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CAL_BEGIN,
        OP_CAL_FINISH,
        OP_STREAM_RESET
    } opcode_t;

    typedef enum logic [2:0] {
        REG_THR_LOW,
        REG_THR_HIGH,
        REG_POLARITY,
        REG_CONFIRM,
        REG_HYST_PCT,
        REG_MIN_CONTRAST
    } reg_idx_t;

    typedef struct packed {
        logic                    polarity_inv;
        logic [CONFIRM_BITS-1:0] confirm_time;
    } ctrl_cfg_t;

    typedef struct packed {
        logic low;
        logic high;
    } thr_load_t;

    typedef struct packed {
        logic comparator_state;
        logic rising_edge;
        logic falling_edge;
        logic discontinuity;
        logic calibration_ok;
        logic calibrated_flag;
    } res_flags_t;

    // percent/100 done as multiply by a scaled reciprocal, exact for all
    // products of a sample-wide range and a percent field
    function automatic int hyst_shift(input int sample_bits);
        return sample_bits + PCT_BITS + PCT_DIV_BITS;
    endfunction

    function automatic int hyst_mult(input int sample_bits);
        return ((1 << hyst_shift(sample_bits)) + PCT_DIVISOR - 1) / PCT_DIVISOR;
    endfunction

endpackage

>>> src/fhed_apb_regs.sv
// ----------------------------------------------------------------------------
// fhed_apb_regs
// APB configuration registers with write strobes for the active thresholds.
// ----------------------------------------------------------------------------
module fhed_apb_regs #(
    parameter int SAMPLE_BITS = fhed_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fhed_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fhed_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fhed_pkg::APB_DATA_BITS-1:0] prdata,
    output fhed_pkg::ctrl_cfg_t                ctrl_cfg,
    output logic [SAMPLE_BITS-1:0]             thr_low,
    output logic [SAMPLE_BITS-1:0]             thr_high,
    output logic [SAMPLE_BITS-1:0]             min_contrast,
    output logic [SAMPLE_BITS+12:0]            pct_scaled,
    output fhed_pkg::thr_load_t                thr_load
);

    localparam int SCALED_BITS = fhed_pkg::hyst_shift(SAMPLE_BITS);
    localparam logic [SCALED_BITS-1:0] HYST_MULT =
        SCALED_BITS'(fhed_pkg::hyst_mult(SAMPLE_BITS));

    logic [SAMPLE_BITS-1:0]            thr_low_reg;
    logic [SAMPLE_BITS-1:0]            thr_high_reg;
    logic                              polarity_reg;
    logic [fhed_pkg::CONFIRM_BITS-1:0] confirm_reg;
    logic [fhed_pkg::PCT_BITS-1:0]     pct_reg;
    logic [SCALED_BITS-1:0]            pct_scaled_reg;
    logic [SAMPLE_BITS-1:0]            contrast_reg;
    logic                              wr_en;
    fhed_pkg::reg_idx_t                reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = fhed_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_low_reg    <= SAMPLE_BITS'(fhed_pkg::DEF_THR_LOW);
            thr_high_reg   <= SAMPLE_BITS'(fhed_pkg::DEF_THR_HIGH);
            polarity_reg   <= 1'b0;
            confirm_reg    <= fhed_pkg::CONFIRM_BITS'(fhed_pkg::DEF_CONFIRM);
            pct_reg        <= fhed_pkg::PCT_BITS'(fhed_pkg::DEF_HYST_PCT);
            pct_scaled_reg <= SCALED_BITS'(fhed_pkg::DEF_HYST_PCT) * HYST_MULT;
            contrast_reg   <= SAMPLE_BITS'(fhed_pkg::DEF_MIN_CONTRAST);
        end else if (wr_en) begin
            unique case (reg_idx)
                fhed_pkg::REG_THR_LOW:      thr_low_reg  <= pwdata[SAMPLE_BITS-1:0];
                fhed_pkg::REG_THR_HIGH:     thr_high_reg <= pwdata[SAMPLE_BITS-1:0];
                fhed_pkg::REG_POLARITY:     polarity_reg <= pwdata[0];
                fhed_pkg::REG_CONFIRM:      confirm_reg  <= pwdata[fhed_pkg::CONFIRM_BITS-1:0];
                fhed_pkg::REG_HYST_PCT: begin
                    pct_reg        <= pwdata[fhed_pkg::PCT_BITS-1:0];
                    pct_scaled_reg <= SCALED_BITS'(pwdata[fhed_pkg::PCT_BITS-1:0]) * HYST_MULT;
                end
                fhed_pkg::REG_MIN_CONTRAST: contrast_reg <= pwdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fhed_pkg::REG_THR_LOW:      prdata = fhed_pkg::APB_DATA_BITS'(thr_low_reg);
            fhed_pkg::REG_THR_HIGH:     prdata = fhed_pkg::APB_DATA_BITS'(thr_high_reg);
            fhed_pkg::REG_POLARITY:     prdata = fhed_pkg::APB_DATA_BITS'(polarity_reg);
            fhed_pkg::REG_CONFIRM:      prdata = fhed_pkg::APB_DATA_BITS'(confirm_reg);
            fhed_pkg::REG_HYST_PCT:     prdata = fhed_pkg::APB_DATA_BITS'(pct_reg);
            fhed_pkg::REG_MIN_CONTRAST: prdata = fhed_pkg::APB_DATA_BITS'(contrast_reg);
            default:                    prdata = '0;
        endcase
    end

    assign ctrl_cfg.polarity_inv = polarity_reg;
    assign ctrl_cfg.confirm_time = confirm_reg;
    // new threshold value, loaded into the core on the write strobe
    assign thr_low       = pwdata[SAMPLE_BITS-1:0];
    assign thr_high      = pwdata[SAMPLE_BITS-1:0];
    assign min_contrast  = contrast_reg;
    assign pct_scaled    = pct_scaled_reg;
    assign thr_load.low  = wr_en && (reg_idx == fhed_pkg::REG_THR_LOW);
    assign thr_load.high = wr_en && (reg_idx == fhed_pkg::REG_THR_HIGH);

endmodule

>>> src/fhed_core.sv
// ----------------------------------------------------------------------------
// fhed_core
// Detector state and the single-pass update for one transaction: IIR filter,
// seeding, Schmitt comparator with confirmation time, and calibration.
// ----------------------------------------------------------------------------
module fhed_core #(
    parameter int SAMPLE_BITS = fhed_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  fhed_pkg::opcode_t               item_op,
    input  logic [SAMPLE_BITS-1:0]          item_raw,
    input  logic [fhed_pkg::TIME_BITS-1:0]  item_time,
    input  fhed_pkg::ctrl_cfg_t             ctrl_cfg,
    input  logic [SAMPLE_BITS-1:0]          thr_low_wr,
    input  logic [SAMPLE_BITS-1:0]          thr_high_wr,
    input  logic [SAMPLE_BITS-1:0]          min_contrast,
    input  logic [SAMPLE_BITS+12:0]         pct_scaled,
    input  fhed_pkg::thr_load_t             thr_load,
    output logic [SAMPLE_BITS-1:0]          res_filt,
    output logic [fhed_pkg::TIME_BITS-1:0]  res_time,
    output fhed_pkg::res_flags_t            res_flags
);

    localparam int W     = SAMPLE_BITS;
    localparam int AW    = W + 2;
    localparam int HS    = fhed_pkg::hyst_shift(W);
    localparam int PW    = W + HS;
    localparam logic [W-1:0] SMAX = {W{1'b1}};

    logic [AW-1:0]                   acc_reg, acc_next;
    logic [W-1:0]                    filt_reg, filt_next;
    logic                            lvl_reg, lvl_next;
    logic                            seeded_reg, seeded_next;
    logic                            pend_reg, pend_next;
    logic [fhed_pkg::TIME_BITS-1:0]  cst_reg, cst_next;
    logic [W-1:0]                    min_reg, min_next;
    logic [W-1:0]                    max_reg, max_next;
    logic                            cal_reg, cal_next;
    logic                            valid_reg, valid_next;
    logic [W-1:0]                    thr_lo_reg, thr_lo_next;
    logic [W-1:0]                    thr_hi_reg, thr_hi_next;

    logic signed [W+1:0]             diff, half;
    logic [W-1:0]                    mid;
    logic [AW-1:0]                   acc0, acc1;
    logic [W-1:0]                    filt;
    logic                            lvl0, cmp_lvl;
    logic [fhed_pkg::TIME_BITS-1:0]  start_t, elapsed;
    logic [W-1:0]                    range_v, center, hyst_raw, hyst;
    logic [PW-1:0]                   prod;
    logic [W:0]                      hi_sum;
    logic                            range_ok;

    function automatic logic level_from(input logic inv, input logic [W-1:0] v,
                                        input logic [W-1:0] m);
        return inv ? (v < m) : (v >= m);
    endfunction

    always_comb begin
        // seed midpoint, truncated toward zero even when high < low
        diff = $signed({2'b00, thr_hi_reg}) - $signed({2'b00, thr_lo_reg});
        half = (diff + $signed((W+2)'(diff[W+1]))) >>> 1;
        mid  = W'($unsigned($signed({2'b00, thr_lo_reg}) + half));

        acc0 = seeded_reg ? acc_reg : {item_raw, 2'b00};
        lvl0 = seeded_reg ? lvl_reg : level_from(ctrl_cfg.polarity_inv, item_raw, mid);
        acc1 = acc0 - (acc0 >> 2) + AW'(item_raw);
        filt = acc1[AW-1:2];

        cmp_lvl = lvl0;
        if (valid_reg) begin
            if (!ctrl_cfg.polarity_inv) begin
                if (!lvl0 && (filt > thr_hi_reg)) cmp_lvl = 1'b1;
                if (lvl0 && (filt < thr_lo_reg))  cmp_lvl = 1'b0;
            end else begin
                if (!lvl0 && (filt < thr_lo_reg)) cmp_lvl = 1'b1;
                if (lvl0 && (filt > thr_hi_reg))  cmp_lvl = 1'b0;
            end
        end
        start_t = pend_reg ? cst_reg : item_time;
        elapsed = item_time - start_t;

        range_v  = max_reg - min_reg;
        range_ok = (max_reg > min_reg) && (range_v >= min_contrast);
        center   = min_reg + (range_v >> 1);
        prod     = PW'(range_v) * PW'(pct_scaled);
        hyst_raw = prod[HS +: W];
        hyst     = (hyst_raw < W'(fhed_pkg::HYST_MIN)) ? W'(fhed_pkg::HYST_MIN) : hyst_raw;
        hi_sum   = {1'b0, center} + {1'b0, hyst};

        acc_next    = acc_reg;
        filt_next   = filt_reg;
        lvl_next    = lvl_reg;
        seeded_next = seeded_reg;
        pend_next   = pend_reg;
        cst_next    = cst_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        cal_next    = cal_reg;
        valid_next  = valid_reg;
        thr_lo_next = thr_lo_reg;
        thr_hi_next = thr_hi_reg;

        res_filt  = '0;
        res_time  = item_time;
        res_flags = '0;

        unique case (item_op)
            fhed_pkg::OP_SAMPLE: begin
                acc_next    = acc1;
                filt_next   = filt;
                seeded_next = 1'b1;
                res_filt    = filt;
                if (cal_reg) begin
                    if (filt < min_reg) min_next = filt;
                    if (filt > max_reg) max_next = filt;
                end
                lvl_next  = lvl0;
                pend_next = 1'b0;
                if (cmp_lvl != lvl0) begin
                    cst_next = start_t;
                    if (elapsed < fhed_pkg::TIME_BITS'(ctrl_cfg.confirm_time)) begin
                        pend_next = 1'b1;
                    end else begin
                        lvl_next = cmp_lvl;
                        res_time = start_t;
                    end
                end
                res_flags.rising_edge  = !lvl0 && lvl_next;
                res_flags.falling_edge = lvl0 && !lvl_next;
            end
            fhed_pkg::OP_CAL_BEGIN: begin
                min_next   = SMAX;
                max_next   = '0;
                cal_next   = 1'b1;
                valid_next = 1'b0;
            end
            fhed_pkg::OP_CAL_FINISH: begin
                cal_next = 1'b0;
                if (range_ok) begin
                    thr_lo_next = (center > hyst) ? center - hyst : '0;
                    thr_hi_next = (hi_sum > {1'b0, SMAX}) ? SMAX : hi_sum[W-1:0];
                    lvl_next    = level_from(ctrl_cfg.polarity_inv, filt_reg, center);
                    pend_next   = 1'b0;
                    valid_next  = 1'b1;
                    res_flags.calibration_ok = 1'b1;
                end else begin
                    valid_next = 1'b0;
                end
            end
            fhed_pkg::OP_STREAM_RESET: begin
                seeded_next = 1'b0;
                pend_next   = 1'b0;
                res_flags.discontinuity = 1'b1;
            end
            default: ;
        endcase

        res_flags.comparator_state = lvl_next;
        res_flags.calibrated_flag  = valid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            filt_reg   <= '0;
            lvl_reg    <= 1'b0;
            seeded_reg <= 1'b0;
            pend_reg   <= 1'b0;
            cst_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            cal_reg    <= 1'b0;
            valid_reg  <= 1'b1;
            thr_lo_reg <= W'(fhed_pkg::DEF_THR_LOW);
            thr_hi_reg <= W'(fhed_pkg::DEF_THR_HIGH);
        end else begin
            if (adv) begin
                acc_reg    <= acc_next;
                filt_reg   <= filt_next;
                lvl_reg    <= lvl_next;
                seeded_reg <= seeded_next;
                pend_reg   <= pend_next;
                cst_reg    <= cst_next;
                min_reg    <= min_next;
                max_reg    <= max_next;
                cal_reg    <= cal_next;
                valid_reg  <= valid_next;
            end
            if (thr_load.low) begin
                thr_lo_reg <= thr_low_wr;
            end else if (adv) begin
                thr_lo_reg <= thr_lo_next;
            end
            if (thr_load.high) begin
                thr_hi_reg <= thr_high_wr;
            end else if (adv) begin
                thr_hi_reg <= thr_hi_next;
            end
        end
    end

    a_no_double_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_flags.rising_edge && res_flags.falling_edge))
        else $error("rising and falling edge on one transaction");

    a_cal_begin: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && item_op == fhed_pkg::OP_CAL_BEGIN) |=> (cal_reg && !valid_reg))
        else $error("begin calibration did not arm tracking");

    a_edge_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (res_flags.rising_edge || res_flags.falling_edge)) |=> !pend_reg)
        else $error("crossing still pending after confirmed edge");

endmodule

>>> src/filtered_hysteresis_edge_detector.sv
// ----------------------------------------------------------------------------
// filtered_hysteresis_edge_detector
// Path: an accepted transaction goes to the input register, then its result
// to the result register, which drives m_tvalid. Throughput: one transaction
// per cycle unless m_tready stalls a full output; the filter, comparator and
// calibration update for an item completes in one pass of fhed_core.
// Reset (aresetn low, synchronous) clears the pipeline, loads the default
// register values and thresholds, and unseeds the filter.
// ----------------------------------------------------------------------------
module filtered_hysteresis_edge_detector #(
    parameter int SAMPLE_BITS = fhed_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_value, time_us
    input  logic [((SAMPLE_BITS+39)/8)*8-1:0]  s_tdata,
    // opcode
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // filtered_value, comparator_state, rising_edge, falling_edge,
    // edge_time_us, discontinuity, calibration_ok, calibrated_flag
    output logic [((SAMPLE_BITS+45)/8)*8-1:0]  m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fhed_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fhed_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fhed_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    localparam int W        = SAMPLE_BITS;
    localparam int TB       = fhed_pkg::TIME_BITS;
    localparam int OUT_BITS = ((W + 45) / 8) * 8;
    localparam int RES_BITS = W + TB + 6;

    fhed_pkg::ctrl_cfg_t  ctrl_cfg;
    fhed_pkg::thr_load_t  thr_load;
    fhed_pkg::res_flags_t res_flags;
    logic [W-1:0]         thr_low, thr_high, min_contrast;
    logic [W+12:0]        pct_scaled;

    logic                 in_valid_reg;
    fhed_pkg::opcode_t    in_op_reg;
    logic [W-1:0]         in_raw_reg;
    logic [TB-1:0]        in_time_reg;
    logic                 out_valid_reg;
    logic [RES_BITS-1:0]  out_data_reg;
    logic                 adv;
    logic [W-1:0]         res_filt;
    logic [TB-1:0]        res_time;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'(out_data_reg);
    assign pready   = 1'b1;

    fhed_apb_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .ctrl_cfg     (ctrl_cfg),
        .thr_low      (thr_low),
        .thr_high     (thr_high),
        .min_contrast (min_contrast),
        .pct_scaled   (pct_scaled),
        .thr_load     (thr_load)
    );

    fhed_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .item_op      (in_op_reg),
        .item_raw     (in_raw_reg),
        .item_time    (in_time_reg),
        .ctrl_cfg     (ctrl_cfg),
        .thr_low_wr   (thr_low),
        .thr_high_wr  (thr_high),
        .min_contrast (min_contrast),
        .pct_scaled   (pct_scaled),
        .thr_load     (thr_load),
        .res_filt     (res_filt),
        .res_time     (res_time),
        .res_flags    (res_flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= fhed_pkg::opcode_t'(s_tuser);
            in_raw_reg  <= s_tdata[W-1:0];
            in_time_reg <= s_tdata[W +: TB];
        end
        if (adv) begin
            out_data_reg <= {res_flags.calibrated_flag, res_flags.calibration_ok,
                             res_flags.discontinuity, res_time,
                             res_flags.falling_edge, res_flags.rising_edge,
                             res_flags.comparator_state, res_filt};
        end
    end

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_time_reg)))
        else $error("stalled input transaction lost");

    a_result_from_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && !adv) |=> !out_valid_reg)
        else $error("result appeared without an advancing transaction");

endmodule

>>> sim/fhed_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fhed_result_checker
// Watches the register port and both streams of the edge detector, keeps its
// own copy of the filter, comparator and calibration state, and checks every
// result transaction field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module fhed_result_checker
    import fhed_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [((SAMPLE_BITS+39)/8)*8-1:0]  s_tdata,
    input  logic [1:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [((SAMPLE_BITS+45)/8)*8-1:0]  m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [APB_ADDR_BITS-1:0]           paddr,
    input  logic [APB_DATA_BITS-1:0]           pwdata,
    output int                                 results_seen,
    output int                                 error_count
);

    localparam int SB     = SAMPLE_BITS;
    localparam int OUT_W  = ((SB + 45) / 8) * 8;
    localparam int SMAX   = (1 << SB) - 1;
    // result field positions in m_tdata
    localparam int P_LVL  = SB;
    localparam int P_RISE = SB + 1;
    localparam int P_FALL = SB + 2;
    localparam int P_TIME = SB + 3;
    localparam int P_DISC = SB + 35;
    localparam int P_OK   = SB + 36;
    localparam int P_CAL  = SB + 37;

    typedef struct packed {
        logic [SB-1:0] filtered;
        logic          level;
        logic          rise;
        logic          fall;
        logic [31:0]   edge_time;
        logic          disc;
        logic          cal_ok;
        logic          calibrated;
    } detector_result_t;

    detector_result_t expected_results[$];
    int               results_total;
    int               errors;

    // register mirror
    logic                    cfg_inv;
    logic [CONFIRM_BITS-1:0] cfg_confirm;
    logic [PCT_BITS-1:0]     cfg_pct;
    logic [SB-1:0]           cfg_contrast;

    // detector state
    logic [SB+1:0] filt_acc;
    logic [SB-1:0] filt_last;
    logic          level;
    logic          seeded;
    logic          crossing;
    logic [31:0]   cross_t;
    logic [SB-1:0] trk_min;
    logic [SB-1:0] trk_max;
    logic          calibrating;
    logic          thr_valid;
    logic [SB-1:0] thr_lo;
    logic [SB-1:0] thr_hi;

    task automatic reset_model();
        cfg_inv      = 1'b0;
        cfg_confirm  = CONFIRM_BITS'(DEF_CONFIRM);
        cfg_pct      = PCT_BITS'(DEF_HYST_PCT);
        cfg_contrast = SB'(DEF_MIN_CONTRAST);
        filt_acc     = '0;
        filt_last    = '0;
        level        = 1'b0;
        seeded       = 1'b0;
        crossing     = 1'b0;
        cross_t      = '0;
        trk_min      = '0;
        trk_max      = '0;
        calibrating  = 1'b0;
        thr_valid    = 1'b1;
        thr_lo       = SB'(DEF_THR_LOW);
        thr_hi       = SB'(DEF_THR_HIGH);
    endtask

    task automatic write_register(logic [APB_ADDR_BITS-1:0] addr, logic [31:0] value);
        case (reg_idx_t'(addr[APB_ADDR_BITS-1:2]))
            REG_THR_LOW:      thr_lo       = value[SB-1:0];
            REG_THR_HIGH:     thr_hi       = value[SB-1:0];
            REG_POLARITY:     cfg_inv      = value[0];
            REG_CONFIRM:      cfg_confirm  = value[CONFIRM_BITS-1:0];
            REG_HYST_PCT:     cfg_pct      = value[PCT_BITS-1:0];
            REG_MIN_CONTRAST: cfg_contrast = value[SB-1:0];
            default: ;
        endcase
    endtask

    function automatic logic level_for(int value, int mid);
        return cfg_inv ? (value < mid) : (value >= mid);
    endfunction

    function automatic detector_result_t step_detector(opcode_t op, logic [SB-1:0] raw,
                                                       logic [31:0] t_us);
        detector_result_t r;
        logic             nxt;
        logic             above;
        logic             below;
        logic [31:0]      elapsed;
        int               acc;
        int               mid;
        int               rng;
        int               center;
        int               hyst;
        r = '0;
        r.edge_time = t_us;
        case (op)
            OP_SAMPLE: begin
                if (!seeded) begin
                    // truncating division keeps this valid for crossed thresholds
                    mid = int'(thr_lo) + (int'(thr_hi) - int'(thr_lo)) / 2;
                    filt_acc  = {raw, 2'b00};
                    filt_last = raw;
                    level     = level_for(int'(raw), mid);
                    seeded    = 1'b1;
                end
                acc = int'(filt_acc);
                acc = acc - (acc >> 2) + int'(raw);
                filt_acc  = (SB+2)'(acc);
                filt_last = filt_acc[SB+1:2];
                r.filtered = filt_last;
                if (calibrating) begin
                    if (filt_last < trk_min) trk_min = filt_last;
                    if (filt_last > trk_max) trk_max = filt_last;
                end
                nxt = level;
                if (thr_valid) begin
                    above = filt_last > thr_hi;
                    below = filt_last < thr_lo;
                    if (!cfg_inv) begin
                        if (!level && above) nxt = 1'b1;
                        if (level && below)  nxt = 1'b0;
                    end else begin
                        if (!level && below) nxt = 1'b1;
                        if (level && above)  nxt = 1'b0;
                    end
                end
                if (nxt != level) begin
                    if (!crossing) begin
                        crossing = 1'b1;
                        cross_t  = t_us;
                    end
                    elapsed = t_us - cross_t;
                    if (elapsed < {16'd0, cfg_confirm}) begin
                        nxt = level;
                    end else begin
                        r.edge_time = cross_t;
                        crossing    = 1'b0;
                    end
                end else begin
                    crossing = 1'b0;
                end
                r.rise = !level && nxt;
                r.fall = level && !nxt;
                level  = nxt;
            end
            OP_CAL_BEGIN: begin
                trk_min     = SB'(SMAX);
                trk_max     = '0;
                calibrating = 1'b1;
                thr_valid   = 1'b0;
            end
            OP_CAL_FINISH: begin
                calibrating = 1'b0;
                rng = int'(trk_max) - int'(trk_min);
                if (rng <= 0 || rng < int'(cfg_contrast)) begin
                    thr_valid = 1'b0;
                end else begin
                    center = int'(trk_min) + rng / 2;
                    hyst   = rng * int'(cfg_pct) / PCT_DIVISOR;
                    if (hyst < HYST_MIN) hyst = HYST_MIN;
                    thr_lo    = SB'(center > hyst ? center - hyst : 0);
                    thr_hi    = SB'(center + hyst > SMAX ? SMAX : center + hyst);
                    level     = level_for(int'(filt_last), center);
                    crossing  = 1'b0;
                    thr_valid = 1'b1;
                    r.cal_ok  = 1'b1;
                end
            end
            default: begin
                seeded   = 1'b0;
                crossing = 1'b0;
                r.disc   = 1'b1;
            end
        endcase
        r.level      = level;
        r.calibrated = thr_valid;
        return r;
    endfunction

    task automatic report_error(string what, logic [31:0] want, logic [31:0] got);
        $display("ERROR @%0t: result %0d %s: expected 0x%0h, got 0x%0h",
                 $time, results_total, what, want, got);
        errors++;
    endtask

    task automatic check_result(logic [OUT_W-1:0] d);
        detector_result_t want;
        results_total++;
        if (expected_results.size() == 0) begin
            report_error("arrived with no transaction outstanding", 32'd0, d[31:0]);
            return;
        end
        want = expected_results.pop_front();
        if (d[SB-1:0] !== want.filtered)
            report_error("filtered_value", 32'(want.filtered), 32'(d[SB-1:0]));
        if (d[P_LVL] !== want.level)
            report_error("comparator_state", 32'(want.level), 32'(d[P_LVL]));
        if (d[P_RISE] !== want.rise)
            report_error("rising_edge", 32'(want.rise), 32'(d[P_RISE]));
        if (d[P_FALL] !== want.fall)
            report_error("falling_edge", 32'(want.fall), 32'(d[P_FALL]));
        if (d[P_TIME+31:P_TIME] !== want.edge_time)
            report_error("edge_time_us", want.edge_time, d[P_TIME+31:P_TIME]);
        if (d[P_DISC] !== want.disc)
            report_error("discontinuity", 32'(want.disc), 32'(d[P_DISC]));
        if (d[P_OK] !== want.cal_ok)
            report_error("calibration_ok", 32'(want.cal_ok), 32'(d[P_OK]));
        if (d[P_CAL] !== want.calibrated)
            report_error("calibrated_flag", 32'(want.calibrated), 32'(d[P_CAL]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                write_register(paddr, pwdata);
            if (s_tvalid && s_tready)
                expected_results.push_back(step_detector(opcode_t'(s_tuser),
                                                         s_tdata[SB-1:0],
                                                         s_tdata[SB+31:SB]));
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
        results_seen <= results_total;
        error_count  <= errors;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the filtered hysteresis edge detector with a directed opening and
// random waveform, calibration and stream-reset traffic under several
// register settings and idle patterns; the result checker scores every
// transaction and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import fhed_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int IN_W        = ((SB + 39) / 8) * 8;
    localparam int OUT_W       = ((SB + 45) / 8) * 8;
    localparam int SMAX        = (1 << SB) - 1;
    localparam int CYCLE_LIMIT = 200000;

    logic                     aclk;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_W-1:0]          s_tdata  = '0;
    logic [1:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_W-1:0]         m_tdata;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int          results_seen;
    int          error_count;
    int          items_sent     = 0;
    int          op_count[4]    = '{0, 0, 0, 0};
    int          send_gap_pct   = 7;
    int          recv_stall_pct = 59;
    int          cycle_count    = 0;
    logic [31:0] now_us         = '0;
    logic        wave_hi        = 1'b0;
    int          wave_left      = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    filtered_hysteresis_edge_detector #(.SAMPLE_BITS(SB)) dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    fhed_result_checker #(.SAMPLE_BITS(SB)) result_check (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .results_seen, .error_count
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(opcode_t op, logic [SB-1:0] value, logic [31:0] t_us);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({t_us, value});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        op_count[op]++;
    endtask

    function automatic logic [31:0] next_time_us();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)      now_us = now_us + $urandom_range(0, 150);
        else if (r < 97) now_us = now_us + $urandom_range(0, 100000);
        else             now_us = $urandom();
        return now_us;
    endfunction

    // square-ish wave with noise so the comparator sees real crossings
    function automatic logic [SB-1:0] pick_sample();
        if (wave_left == 0) begin
            wave_hi   = ~wave_hi;
            wave_left = $urandom_range(3, 30);
        end
        wave_left--;
        if ($urandom_range(0, 9) == 0) return SB'($urandom_range(0, SMAX));
        return wave_hi ? SB'($urandom_range(2600, SMAX)) : SB'($urandom_range(0, 1500));
    endfunction

    task automatic send_sample();
        send_item(OP_SAMPLE, pick_sample(), next_time_us());
    endtask

    task automatic send_command(opcode_t op);
        send_item(op, SB'($urandom_range(0, SMAX)), next_time_us());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic configure(int lo, int hi, int inv, int confirm, int pct, int contrast);
        drain();
        apb_write(REG_THR_LOW, lo);
        apb_write(REG_THR_HIGH, hi);
        apb_write(REG_POLARITY, inv);
        apb_write(REG_CONFIRM, confirm);
        apb_write(REG_HYST_PCT, pct);
        apb_write(REG_MIN_CONTRAST, contrast);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        send_gap_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic run_random(int n);
        int start;
        int kind;
        int len;
        start  = items_sent;
        now_us = $urandom();
        while (items_sent - start < n) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(3, 30);
            if (kind < 62) begin
                repeat (len) send_sample();
            end else if (kind < 80) begin
                send_command(OP_CAL_BEGIN);
                repeat (len) send_sample();
                send_command(OP_CAL_FINISH);
            end else if (kind < 88) begin
                send_command(OP_STREAM_RESET);
                repeat (len % 8 + 1) send_sample();
            end else if (kind < 93) begin
                send_command(OP_CAL_FINISH);
            end else begin
                repeat (len % 5 + 1)
                    send_item(opcode_t'($urandom_range(0, 3)), SB'($urandom_range(0, SMAX)),
                              $urandom());
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: finish with nothing tracked, frozen comparator, seeding,
        // calibration, a confirmed rise across the timestamp wrap, a fall
        // confirmed exactly at the confirm time, reseed, empty calibration
        send_item(OP_CAL_FINISH,   SB'(0),    32'd5);
        send_item(OP_SAMPLE,       SB'(0),    32'd0);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'd10);
        send_item(OP_STREAM_RESET, SB'(SMAX), 32'd20);
        send_item(OP_CAL_BEGIN,    SB'(0),    32'd30);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'd40);
        send_item(OP_SAMPLE,       SB'(0),    32'd50);
        send_item(OP_SAMPLE,       SB'(0),    32'd60);
        send_item(OP_SAMPLE,       SB'(0),    32'd70);
        send_item(OP_SAMPLE,       SB'(0),    32'd80);
        send_item(OP_CAL_FINISH,   SB'(0),    32'd90);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'hFFFF_FF00);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'hFFFF_FF40);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'hFFFF_FF80);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'hFFFF_FFC0);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'hFFFF_FFFF);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'h0000_0100);
        send_item(OP_SAMPLE,       SB'(0),    32'h0000_0200);
        send_item(OP_SAMPLE,       SB'(0),    32'h0000_0300);
        send_item(OP_SAMPLE,       SB'(0),    32'h0000_03C8);
        send_item(OP_SAMPLE,       SB'(SMAX), 32'h0000_0400);
        send_item(OP_STREAM_RESET, SB'(0),    32'hFFFF_FFFF);
        send_item(OP_SAMPLE,       SB'(2048), 32'h0000_0500);
        send_item(OP_CAL_BEGIN,    SB'(0),    32'h0000_0600);
        send_item(OP_CAL_FINISH,   SB'(SMAX), 32'h0000_0700);

        // zero confirm time, zero hysteresis, zero contrast
        configure(1000, 3000, 0, 0, 0, 0);
        run_random(330);

        // crossed thresholds, inverted, longest confirm, 50 percent hysteresis
        set_idle(59, 7);
        configure(SMAX, 0, 1, 16'hFFFF, 50, SMAX);
        run_random(330);

        set_idle(0, 0);
        configure($urandom_range(0, SMAX), $urandom_range(0, SMAX), $urandom_range(0, 1),
                  $urandom_range(0, 400), $urandom_range(0, 63), $urandom_range(0, 600));
        run_random(340);

        drain();
        repeat (8) @(posedge aclk);
        $display("Ran %0d transactions: %0d samples, %0d calibration starts,",
                 items_sent, op_count[OP_SAMPLE], op_count[OP_CAL_BEGIN],
                 " %0d finishes, %0d stream resets",
                 op_count[OP_CAL_FINISH], op_count[OP_STREAM_RESET]);
        $display("Register sets: defaults, zero timing and hysteresis, ",
                 "crossed inverted extremes, random; three idle patterns");
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
